// ----- design/aesgcm_pkg.sv -----
package aesgcm_pkg;

    localparam int NumRoundKeys = 15;
    localparam int GhDigit      = 8;

    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    localparam logic [2:0] CFG_HKEY_HI = 3'd0;
    localparam logic [2:0] CFG_HKEY_LO = 3'd1;
    localparam logic [2:0] CFG_IV_HI   = 3'd2;
    localparam logic [2:0] CFG_IV_LO   = 3'd3;
    localparam logic [2:0] CFG_CTR     = 3'd4;

    localparam logic [3:0] LAST_ROUND = 4'd14;

    localparam logic [127:0] GCM_R = {8'he1, 120'd0};

    typedef struct packed {
        logic         we;
        logic [3:0]   idx;
        logic [127:0] data;
    } t_key_wr;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte 0 sits in the top bits of the state word
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
                                               input logic last);
        logic [7:0]   t [16];
        logic [7:0]   m [16];
        logic [7:0]   a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4 * c] = SBOX[s[127 - 8 * (i + 4 * ((c + i) % 4)) -: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4 * c];
            a1 = t[4 * c + 1];
            a2 = t[4 * c + 2];
            a3 = t[4 * c + 3];
            al = a0 ^ a1 ^ a2 ^ a3;
            m[4 * c]     = last ? a0 : (a0 ^ al ^ xtime(a0 ^ a1));
            m[4 * c + 1] = last ? a1 : (a1 ^ al ^ xtime(a1 ^ a2));
            m[4 * c + 2] = last ? a2 : (a2 ^ al ^ xtime(a2 ^ a3));
            m[4 * c + 3] = last ? a3 : (a3 ^ al ^ xtime(a3 ^ a0));
        end
        for (int b = 0; b < 16; b++) begin
            r[127 - 8 * b -: 8] = m[b];
        end
        return r ^ k;
    endfunction

endpackage

// ----- design/aesgcm_in_if.sv -----
interface aesgcm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  key_index;
    logic [63:0] data_hi;
    logic [63:0] data_lo;

    modport source(output valid, kind, key_index, data_hi, data_lo, input ready);
    modport sink(input valid, kind, key_index, data_hi, data_lo, output ready);
    modport monitor(input valid, ready, kind, key_index, data_hi, data_lo);
endinterface

// ----- design/aesgcm_out_if.sv -----
interface aesgcm_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;
    logic [63:0] hash_hi;
    logic [63:0] hash_lo;

    modport source(output valid, cipher_hi, cipher_lo, hash_hi, hash_lo, input ready);
    modport sink(input valid, cipher_hi, cipher_lo, hash_hi, hash_lo, output ready);
    modport monitor(input valid, ready, cipher_hi, cipher_lo, hash_hi, hash_lo);
endinterface

// ----- design/aesgcm_aes_core.sv -----
module aesgcm_aes_core
    import aesgcm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_key_wr      i_key_wr,
    input  logic         i_start,
    input  logic [127:0] i_block,
    output logic         o_done,
    output logic [127:0] o_ks
);
    logic [127:0] r_rk [NumRoundKeys];
    logic [127:0] r_state;
    logic [3:0]   r_round;
    logic         r_busy;
    logic         r_done;
    logic [3:0]   rd_idx;
    logic [127:0] rk;

    assign rd_idx = r_busy ? r_round : 4'd0;
    assign rk     = r_rk[rd_idx];

    always_ff @(posedge i_clk) begin
        if (i_key_wr.we) begin
            r_rk[i_key_wr.idx] <= i_key_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_state <= i_block ^ rk;
                r_round <= 4'd1;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_state <= aes_round(r_state, rk, r_round == LAST_ROUND);
                if (r_round == LAST_ROUND) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_round <= r_round + 4'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_ks   = r_state;
endmodule

// ----- design/aesgcm_ghash.sv -----
module aesgcm_ghash
    import aesgcm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_x,
    input  logic [127:0] i_h,
    output logic         o_done,
    output logic [127:0] o_z
);
    logic [127:0] r_x, r_v, r_z;
    logic [3:0]   r_cnt;
    logic         r_busy, r_done;
    logic [127:0] n_x, n_v, n_z;

    // one byte of x per cycle, msb first
    always_comb begin
        n_x = r_x;
        n_v = r_v;
        n_z = r_z;
        for (int j = 0; j < GhDigit; j++) begin
            if (n_x[127]) begin
                n_z = n_z ^ n_v;
            end
            n_v = {1'b0, n_v[127:1]} ^ (n_v[0] ? GCM_R : 128'd0);
            n_x = {n_x[126:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_x;
                r_v    <= i_h;
                r_z    <= 128'd0;
                r_cnt  <= 4'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_x   <= n_x;
                r_v   <= n_v;
                r_z   <= n_z;
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_z    = r_z;
endmodule

// ----- design/aes256_gcm_encrypt_ghash.sv -----
// channel   dir  payload                                   request taken when
// i_in      in   kind, key_index, data_hi, data_lo         valid && ready
// o_res     out  cipher_hi, cipher_lo, hash_hi, hash_lo    valid && ready
// cfg       in   i_cfg_idx, i_cfg_data                     i_cfg_we
//
// a data block runs through aes (key add on the request edge, then one round per
// cycle), a handoff on aes_done, ghash (one byte of the multiplier per cycle) and
// ST_OUT, which loads the output register and raises o_res.valid; the next request
// is taken only once ST_OUT has returned to idle
// key and message-start requests are taken in idle and leave the state in idle
// input ready only while idle; a finished result sits in the output register
// while the next request is taken, a stalled output holds the last block
// reset is synchronous, active low; round keys are not cleared
module aes256_gcm_encrypt_ghash
    import aesgcm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    aesgcm_in_if.sink    i_in,
    aesgcm_out_if.source o_res,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [63:0]  i_cfg_data
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_AES  = 2'd1;
    localparam logic [1:0] ST_GH   = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]   r_st;
    logic [63:0]  r_h_hi, r_h_lo, r_iv_hi;
    logic [31:0]  r_iv_lo, r_ctr_start, r_ctr;
    logic [127:0] r_acc, r_data, r_cipher, r_ocipher, r_ohash;
    logic         r_ovalid;

    logic         acc;
    t_key_wr      key_wr;
    logic         aes_start, aes_done, gh_done;
    logic [127:0] ks, cipher, gh_z;

    assign i_in.ready = (r_st == ST_IDLE);
    assign acc        = i_in.valid && i_in.ready;

    assign key_wr.we   = acc && (i_in.kind == KIND_KEY) && (i_in.key_index <= LAST_ROUND);
    assign key_wr.idx  = i_in.key_index;
    assign key_wr.data = {i_in.data_hi, i_in.data_lo};
    assign aes_start   = acc && (i_in.kind == KIND_DATA);
    assign cipher      = ks ^ r_data;

    aesgcm_aes_core u_aes (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key_wr(key_wr),
        .i_start (aes_start),
        .i_block ({r_iv_hi, r_iv_lo, r_ctr}),
        .o_done  (aes_done),
        .o_ks    (ks)
    );

    aesgcm_ghash u_gh (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(aes_done),
        .i_x    (r_acc ^ cipher),
        .i_h    ({r_h_hi, r_h_lo}),
        .o_done (gh_done),
        .o_z    (gh_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_hi      <= 64'd0;
            r_h_lo      <= 64'd0;
            r_iv_hi     <= 64'd0;
            r_iv_lo     <= 32'd0;
            r_ctr_start <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HKEY_HI: r_h_hi      <= i_cfg_data;
                CFG_HKEY_LO: r_h_lo      <= i_cfg_data;
                CFG_IV_HI:   r_iv_hi     <= i_cfg_data;
                CFG_IV_LO:   r_iv_lo     <= i_cfg_data[31:0];
                CFG_CTR:     r_ctr_start <= i_cfg_data[31:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_acc    <= 128'd0;
            r_ctr    <= 32'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_st == ST_OUT && (!r_ovalid || o_res.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_st)
                ST_IDLE: begin
                    if (acc && i_in.kind == KIND_START) begin
                        r_acc <= {i_in.data_hi, i_in.data_lo};
                        r_ctr <= r_ctr_start;
                    end
                    if (aes_start) begin
                        r_data <= {i_in.data_hi, i_in.data_lo};
                        r_st   <= ST_AES;
                    end
                end
                ST_AES: begin
                    if (aes_done) begin
                        r_cipher <= cipher;
                        r_st     <= ST_GH;
                    end
                end
                ST_GH: begin
                    if (gh_done) begin
                        r_acc <= gh_z;
                        r_ctr <= r_ctr + 32'd1;
                        r_st  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // wait for the previous result to drain
                    if (!r_ovalid || o_res.ready) begin
                        r_ocipher <= r_cipher;
                        r_ohash   <= r_acc;
                        r_st      <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_res.valid     = r_ovalid;
    assign o_res.cipher_hi = r_ocipher[127:64];
    assign o_res.cipher_lo = r_ocipher[63:0];
    assign o_res.hash_hi   = r_ohash[127:64];
    assign o_res.hash_lo   = r_ohash[63:0];
endmodule
